// ===== rtl/csm_pkg.sv =====
// csm_pkg: shared types and constants of the sparse matrix-vector unit
// no dependencies; imported by csm_front, csm_back and the top level
`timescale 1ns / 1ps

package csm_pkg;

    // operation codes of an input transaction
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // fixed field widths
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int ROW_W   = 16;
    localparam int COUNT_W = 11;

    // wide index used for range checks against the store depth
    localparam int WIDE_W = 17;

    // defaults and reset values
    localparam int                 MAX_COLUMNS_DEFAULT = 1024;
    localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET  = 11'd1024;

    // depth of the queue between front and back, and of the result queue
    localparam int QUEUE_DEPTH  = 4;
    localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RESULT_DEPTH = 2;

    // classified matrix item handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] vec;
        logic               mac;
        logic               err;
        logic               row_end;
    } csm_item_t;

    // finished row
    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0] row_index;
        logic             error;
    } csm_result_t;

endpackage

// ===== rtl/csm_ram.sv =====
// csm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csm_queue.sv =====
// csm_queue: small flop-based first-in first-out queue
// no dependencies; used between front and back and for finished rows
`timescale 1ns / 1ps

module csm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/csm_front.sv =====
// csm_front: accepts transactions, holds the vector store, classifies matrix items
// depends on csm_pkg and csm_ram
`timescale 1ns / 1ps

module csm_front
    import csm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                op,
    input  logic [INDEX_W-1:0]  index,
    input  logic [VALUE_W-1:0]  value,
    input  logic                has_entry,
    input  logic                row_end,
    input  logic [COUNT_W-1:0]  column_count,
    input  logic [QCOUNT_W-1:0] q_count,
    output logic                q_push,
    output csm_item_t           q_item
);

    localparam int AW = $clog2(MAX_COLUMNS);

    logic               accept;
    logic [WIDE_W-1:0]  idx_wide;
    logic [AW-1:0]      addr;
    logic               in_store;
    logic               col_ok;
    logic               is_load, is_matrix;
    logic               item_err, item_mac;
    logic               keep;
    logic [VALUE_W-1:0] rdata;

    logic               s1_valid_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic               s1_mac_reg;
    logic               s1_err_reg;
    logic               s1_row_end_reg;

    // credit check: the staged item must find room in the queue next cycle
    assign full = (({1'b0, q_count} + (QCOUNT_W+1)'(s1_valid_reg))
                   >= (QCOUNT_W+1)'(QUEUE_DEPTH));
    assign accept = push && !full;

    // classify the incoming transaction
    assign idx_wide  = WIDE_W'(index);
    assign addr      = idx_wide[AW-1:0];
    assign in_store  = (idx_wide < WIDE_W'(MAX_COLUMNS));
    assign col_ok    = ({1'b0, index} < column_count) && in_store;
    assign is_load   = (op == OP_LOAD);
    assign is_matrix = (op == OP_MATRIX);
    assign item_err  = has_entry && !col_ok;
    assign item_mac  = has_entry && col_ok;
    assign keep      = is_matrix && (has_entry || row_end);

    // vector store: loads write, valid nonzeros read
    csm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_store (
        .clk   (clk),
        .we    (accept && is_load && in_store),
        .waddr (addr),
        .wdata (value),
        .re    (accept && is_matrix && item_mac),
        .raddr (addr),
        .rdata (rdata)
    );

    // stage register waiting for the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            s1_value_reg   <= value;
            s1_mac_reg     <= item_mac;
            s1_err_reg     <= item_err;
            s1_row_end_reg <= row_end;
        end
    end

    // hand the classified item to the queue
    assign q_push          = s1_valid_reg;
    assign q_item.value    = s1_value_reg;
    assign q_item.vec      = s1_mac_reg ? rdata : '0;
    assign q_item.mac      = s1_mac_reg;
    assign q_item.err      = s1_err_reg;
    assign q_item.row_end  = s1_row_end_reg;

    // staged item always finds room in the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_count < QCOUNT_W'(QUEUE_DEPTH)))
        else $error("front pushed into a full queue");

    // a nonzero is either multiplied or flagged, never both
    a_mac_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_mac_reg && s1_err_reg))
        else $error("item both accumulated and flagged");

endmodule

// ===== rtl/csm_back.sv =====
// csm_back: multiply, saturating accumulate and row completion
// depends on csm_pkg
`timescale 1ns / 1ps

module csm_back
    import csm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  csm_item_t   q_item,
    output logic        q_pop,
    input  logic        o_full,
    output logic        o_push,
    output csm_result_t o_result
);

    logic             en;

    logic             p_valid_reg;
    logic [SUM_W-1:0] p_prod_reg;
    logic             p_err_reg;
    logic             p_row_end_reg;

    logic signed [SUM_W-1:0] prod;

    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             err_reg, err_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sat_sum;
    logic             ovf;

    // whole pipeline advances while the result queue has room
    assign en    = !o_full;
    assign q_pop = en && !q_empty;

    // exact signed 32x32 product at full width
    assign prod = $signed(q_item.value) * $signed(q_item.vec);

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_prod_reg    <= q_item.mac ? prod : '0;
            p_err_reg     <= q_item.err;
            p_row_end_reg <= q_item.row_end;
        end
    end

    // saturating add
    always_comb
    begin
        sum     = acc_reg + p_prod_reg;
        ovf     = (acc_reg[SUM_W-1] == p_prod_reg[SUM_W-1])
                  && (sum[SUM_W-1] != acc_reg[SUM_W-1]);
        sat_sum = sum;
        if (ovf)
        begin
            sat_sum = acc_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // accumulate stage and row completion
    assign o_push             = en && p_valid_reg && p_row_end_reg;
    assign o_result.row_sum   = sat_sum;
    assign o_result.row_index = row_cnt_reg;
    assign o_result.error     = err_reg || p_err_reg;

    always_comb
    begin
        acc_next     = acc_reg;
        err_next     = err_reg;
        row_cnt_next = row_cnt_reg;
        if (en && p_valid_reg)
        begin
            if (p_row_end_reg)
            begin
                acc_next     = '0;
                err_next     = 1'b0;
                row_cnt_next = row_cnt_reg + 1'b1;
            end
            else
            begin
                acc_next = sat_sum;
                err_next = err_reg || p_err_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            err_reg     <= 1'b0;
            row_cnt_reg <= '0;
        end
        else
        begin
            acc_reg     <= acc_next;
            err_reg     <= err_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // a finished row restarts from a clean sum and flag
    a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |=> (acc_reg == '0) && !err_reg)
        else $error("row state not cleared after completion");

    // row number steps by one per finished row
    a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |=> (row_cnt_reg == $past(row_cnt_reg) + 1'b1))
        else $error("row counter did not advance");

    // row number moves only on a finished row
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !o_push |=> $stable(row_cnt_reg))
        else $error("row counter moved without a finished row");

endmodule

// ===== rtl/csr_sparse_matrix_vector_multiply_unit.sv =====
// csr_sparse_matrix_vector_multiply_unit: top level of the sparse matrix-vector unit
// depends on csm_pkg, csm_front, csm_queue, csm_back and csm_ram
`timescale 1ns / 1ps

// Multiplies a compressed-row sparse matrix by a dense vector. Load the vector
// first with op = load transactions (index = element, value = Q16.16), then
// stream nonzeros in row order with op = matrix, column in index and Q16.16
// value; row_end on a transaction (with or without an entry) emits the row's
// saturated Q32.32 sum, its row number and an error flag for any column at or
// above column_count. Each element must be loaded before a nonzero reads it.
// The block takes one transaction per clock cycle while full is low. A row result,
// once its row-end transaction is accepted, passes the registered vector store
// read, which completes at the accepting edge, the four-entry queue between the
// front and the back, the 32x32 multiplier register and the saturating 64-bit
// accumulator on its way into a two-entry result queue. full rises only when
// the internal queue backs up behind a stalled result side.
// column_count is written through cfg_valid/cfg_data, always ready, and
// should be changed only while no transaction is in flight.

module csr_sparse_matrix_vector_multiply_unit
    import csm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic [INDEX_W-1:0] index,
    input  logic [VALUE_W-1:0] value,
    input  logic               has_entry,
    input  logic               row_end,
    output logic               empty,
    input  logic               pop,
    output logic [SUM_W-1:0]   row_sum,
    output logic [ROW_W-1:0]   row_index,
    output logic               error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0]  column_count_reg;
    logic [QCOUNT_W-1:0] q_count;
    logic                q_push, q_pop, q_empty;
    csm_item_t           q_in, q_out;
    logic                o_push, o_full;
    csm_result_t         o_in, o_out;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            column_count_reg <= cfg_data;
        end
    end

    // front: accept, store vector, classify
    csm_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .index        (index),
        .value        (value),
        .has_entry    (has_entry),
        .row_end      (row_end),
        .column_count (column_count_reg),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    // queue between front and back
    csm_queue #(
        .WIDTH ($bits(csm_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty),
        .count (q_count)
    );

    // back: multiply and accumulate
    csm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_out),
        .q_pop    (q_pop),
        .o_full   (o_full),
        .o_push   (o_push),
        .o_result (o_in)
    );

    // finished rows wait here for the consumer
    csm_queue #(
        .WIDTH ($bits(csm_result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .din   (o_in),
        .full  (o_full),
        .pop   (pop),
        .dout  (o_out),
        .empty (empty),
        .count ()
    );

    assign row_sum   = o_out.row_sum;
    assign row_index = o_out.row_index;
    assign error     = o_out.error;

endmodule
